// File: rtl/ensemble_weighted_q_factor_unit_defines.svh
// Assertion macros used by the port checker file.
`ifndef ENSEMBLE_WEIGHTED_Q_FACTOR_UNIT_DEFINES_SVH
`define ENSEMBLE_WEIGHTED_Q_FACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define EWQF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ewqf check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define EWQF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ewqf check failed");

`endif

// File: rtl/ewqf_pkg.sv
// Types and constants of the ensemble weighted Q factor unit.
package ewqf_pkg;

    localparam int GENE_W     = 17;
    localparam int DATA_W     = 24;
    localparam int Q_W        = 20;
    localparam int ACC_W      = 48;
    localparam int SUM_W      = 64;
    localparam int RND_W      = 25;
    localparam int DIFF_W     = 26;
    localparam int DIV_QW     = 40;
    localparam int DIV_CW     = 6;
    localparam int SQ_CW      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [GENE_W-1:0] ONE_Q16        = 17'h10000;
    localparam logic [Q_W-1:0]    Q_MAX          = 20'hFFFFF;
    localparam logic [DIV_CW-1:0] GENE_DIV_STEPS = 6'd17;
    localparam logic [DIV_CW-1:0] Q_DIV_STEPS    = 6'd40;
    localparam logic [SQ_CW-1:0]  SQRT_STEPS     = 5'd20;
    localparam logic [DIV_QW-1:0] SQ_BIT0        = 40'h40_0000_0000;

    typedef enum logic [1:0] {
        FUNC_TABLE = 2'd0,
        FUNC_MEAS  = 2'd1,
        FUNC_GENE  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_MODE = 2'd0,
        CFG_CONF_COUNT  = 2'd1,
        CFG_POINT_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GSUM,
        S_GDRAIN,
        S_WREAD,
        S_WCALC,
        S_WWAIT,
        S_MAC,
        S_MDRAIN,
        S_FIN,
        S_FDRAIN,
        S_QDIV,
        S_QWAIT,
        S_SQRT,
        S_SWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic gsum_clr;
        logic gsum_rd;
        logic w_rd;
        logic w_start;
        logic w_last;
        logic used_clr;
        logic mac_issue;
        logic mac_first;
        logic fin_clr;
        logic fin_issue;
        logic qdiv_start;
        logic sqrt_start;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic div_busy;
        logic sqrt_busy;
    } t_stat;

endpackage

// File: rtl/ewqf_in_if.sv
// Input channel: valid/ready handshake with one load or gene transaction.
interface ewqf_in_if;
    import ewqf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [5:0]               conf_index;
    logic [5:0]               point_index;
    logic signed [DATA_W-1:0] data_value;
    logic [GENE_W-1:0]        gene_value;
    logic                     last;

    modport source (output valid, func, conf_index, point_index, data_value, gene_value, last,
                    input ready);
    modport sink (input valid, func, conf_index, point_index, data_value, gene_value, last,
                  output ready);
endinterface

// File: rtl/ewqf_out_if.sv
// Output channel: valid/ready handshake with one Q factor transaction.
interface ewqf_out_if;
    import ewqf_pkg::*;

    logic           valid;
    logic           ready;
    logic [Q_W-1:0] q_factor;
    logic           zero_denominator;
    logic           zero_gene_sum;

    modport source (output valid, q_factor, zero_denominator, zero_gene_sum, input ready);
    modport sink (input valid, q_factor, zero_denominator, zero_gene_sum, output ready);
endinterface

// File: rtl/ewqf_div.sv
// Restoring divider, one quotient bit per cycle.
module ewqf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ewqf_pkg::SUM_W-1:0]   i_rem,
    input  logic [ewqf_pkg::SUM_W-1:0]   i_den,
    input  logic [ewqf_pkg::DIV_QW-1:0]  i_low,
    input  logic [ewqf_pkg::DIV_CW-1:0]  i_steps,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [ewqf_pkg::DIV_QW-1:0]  o_quo
);
    import ewqf_pkg::*;

    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_den;
    logic [DIV_QW-1:0] r_low;
    logic [DIV_QW-1:0] r_quo;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SUM_W:0]    shifted;
    logic [SUM_W:0]    diff;
    logic              fits;

    assign shifted = {r_rem, r_low[DIV_QW-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_den <= i_den;
            r_low <= i_low;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
            r_low <= {r_low[DIV_QW-2:0], 1'b0};
            r_quo <= {r_quo[DIV_QW-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: rtl/ewqf_sqrt.sv
// Integer square root, one result bit per cycle.
module ewqf_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ewqf_pkg::DIV_QW-1:0]  i_x,
    output logic                         o_busy,
    output logic [ewqf_pkg::Q_W-1:0]     o_root
);
    import ewqf_pkg::*;

    logic [DIV_QW-1:0] r_x;
    logic [DIV_QW:0]   r_res;
    logic [DIV_QW-1:0] r_bit;
    logic [SQ_CW-1:0]  r_cnt;
    logic              r_busy;
    logic [DIV_QW:0]   trial;
    logic              fits;

    assign trial = r_res + {1'b0, r_bit};
    assign fits  = {1'b0, r_x} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SQRT_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - SQ_CW'(1);
            if (r_cnt == SQ_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= SQ_BIT0;
        end else if (r_busy) begin
            if (fits) begin
                r_x   <= r_x - trial[DIV_QW-1:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[Q_W-1:0];
endmodule

// File: rtl/ewqf_dp.sv
// Datapath: stores, weight unit, profile accumulation, error sums, divide and root.
module ewqf_dp #(
    parameter  int MAX_CONFS  = 64,
    parameter  int MAX_POINTS = 64,
    localparam int CW         = $clog2(MAX_CONFS),
    localparam int PW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic [1:0]                        i_func,
    input  logic [5:0]                        i_conf_index,
    input  logic [5:0]                        i_point_index,
    input  logic signed [ewqf_pkg::DATA_W-1:0] i_data_value,
    input  logic [ewqf_pkg::GENE_W-1:0]       i_gene_value,
    input  logic                              i_mode,
    input  ewqf_pkg::t_cmd                    i_cmd,
    input  logic [CW-1:0]                     i_conf,
    input  logic [PW-1:0]                     i_point,
    output ewqf_pkg::t_stat                   o_stat,
    output logic [ewqf_pkg::Q_W-1:0]          o_q_factor,
    output logic                              o_zero_denominator,
    output logic                              o_zero_gene_sum
);
    import ewqf_pkg::*;

    localparam int DEPTH = MAX_CONFS * MAX_POINTS;
    localparam int TAW   = $clog2(DEPTH);
    localparam int GSW   = GENE_W + CW;

    logic signed [DATA_W-1:0] r_table [DEPTH];
    logic signed [DATA_W-1:0] r_meas  [MAX_POINTS];
    logic [GENE_W-1:0]        r_genes [MAX_CONFS];
    logic signed [ACC_W-1:0]  r_prof  [MAX_POINTS];

    logic                     tab_we, meas_we, gene_we, prof_rd;
    logic [TAW-1:0]           tab_waddr, tab_raddr;
    logic [GENE_W-1:0]        gene_clamped;

    logic signed [DATA_W-1:0] r_tab_q;
    logic signed [ACC_W-1:0]  r_prof_q;
    logic signed [DATA_W-1:0] r_meas_q;
    logic [GENE_W-1:0]        r_gene_q;

    logic                     r_gs_v;
    logic [GSW-1:0]           r_gsum;
    logic [GENE_W-1:0]        r_w;
    logic [GENE_W-1:0]        r_used;
    logic                     r_w_new;
    logic [GENE_W-1:0]        share;
    logic [2*GENE_W-1:0]      w_prod;

    logic                     r_m1_v, r_m2_v;
    logic [PW-1:0]            r_m1_p, r_m2_p;
    logic                     r_m1_first;
    logic signed [GENE_W+DATA_W:0] mac_prod;
    logic signed [ACC_W-1:0]  r_mprod, r_mbase;

    logic                     r_f1_v, r_f2_v, r_f3_v, r_f4_v;
    logic signed [ACC_W-1:0]  prof_biased;
    logic signed [RND_W-1:0]  r_rnd;
    logic signed [DATA_W-1:0] r_mb;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [DATA_W-1:0]        meas_abs;
    logic [DIFF_W-2:0]        r_ad;
    logic [DATA_W-1:0]        r_am;
    logic [2*DIFF_W-3:0]      r_sqd;
    logic [2*DATA_W-1:0]      r_sqm;
    logic [SUM_W-1:0]         r_num, r_den;

    logic                     den_zero, num_big, r_sat, r_div_gene;
    logic                     gene_div_go, q_div_go;
    logic [SUM_W-1:0]         div_rem, div_den;
    logic [DIV_QW-1:0]        div_low, div_quo;
    logic [DIV_CW-1:0]        div_steps;
    logic                     div_busy, div_done, sqrt_busy;
    logic [Q_W-1:0]           root;

    assign gene_clamped = (i_gene_value > ONE_Q16) ? ONE_Q16 : i_gene_value;
    assign tab_we  = i_acc && (i_func == FUNC_TABLE) && (32'(i_conf_index) < MAX_CONFS)
                     && (32'(i_point_index) < MAX_POINTS);
    assign meas_we = i_acc && (i_func == FUNC_MEAS) && (32'(i_point_index) < MAX_POINTS);
    assign gene_we = i_acc && (i_func == FUNC_GENE) && (32'(i_conf_index) < MAX_CONFS);
    assign tab_waddr = TAW'(32'(i_conf_index) * MAX_POINTS + 32'(i_point_index));
    assign tab_raddr = TAW'(32'(i_conf) * MAX_POINTS + 32'(i_point));
    assign prof_rd   = i_cmd.mac_issue || i_cmd.fin_issue;

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_table[tab_waddr] <= i_data_value;
        end
        if (i_cmd.mac_issue) begin
            r_tab_q <= r_table[tab_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (meas_we) begin
            r_meas[PW'(i_point_index)] <= i_data_value;
        end
        if (i_cmd.fin_issue) begin
            r_meas_q <= r_meas[i_point];
        end
    end

    always_ff @(posedge i_clk) begin
        if (gene_we) begin
            r_genes[CW'(i_conf_index)] <= gene_clamped;
        end
        if (i_cmd.gsum_rd || i_cmd.w_rd) begin
            r_gene_q <= r_genes[i_conf];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_m2_v) begin
            r_prof[r_m2_p] <= r_mbase + r_mprod;
        end
        if (prof_rd) begin
            r_prof_q <= r_prof[i_point];
        end
    end

    // control valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs_v  <= 1'b0;
            r_w_new <= 1'b0;
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            r_f3_v  <= 1'b0;
            r_f4_v  <= 1'b0;
        end else begin
            r_gs_v  <= i_cmd.gsum_rd;
            r_w_new <= i_cmd.w_start && !i_mode;
            r_m1_v  <= i_cmd.mac_issue;
            r_m2_v  <= r_m1_v;
            r_f1_v  <= i_cmd.fin_issue;
            r_f2_v  <= r_f1_v;
            r_f3_v  <= r_f2_v;
            r_f4_v  <= r_f3_v;
        end
    end

    // gene sum and weights
    assign share  = ONE_Q16 - r_used;
    assign w_prod = r_gene_q * share;

    always_ff @(posedge i_clk) begin
        if (i_cmd.gsum_clr) begin
            r_gsum <= '0;
        end else if (r_gs_v) begin
            r_gsum <= r_gsum + GSW'(r_gene_q);
        end
        if (i_cmd.used_clr) begin
            r_used <= '0;
        end else if (r_w_new) begin
            r_used <= r_used + r_w;
        end
        if (i_cmd.w_start) begin
            if (!i_mode) begin
                r_w <= i_cmd.w_last ? share : w_prod[GENE_W+15:16];
            end else if (r_gsum == '0) begin
                r_w <= '0;
            end
        end else if (div_done && r_div_gene) begin
            r_w <= div_quo[GENE_W-1:0];
        end
    end

    // profile multiply-accumulate
    assign mac_prod = $signed({1'b0, r_w}) * r_tab_q;

    always_ff @(posedge i_clk) begin
        r_m1_p     <= i_point;
        r_m1_first <= i_cmd.mac_first;
        r_m2_p     <= r_m1_p;
        r_mprod    <= ACC_W'(mac_prod);
        r_mbase    <= r_m1_first ? '0 : r_prof_q;
    end

    // error sums
    assign prof_biased = r_prof_q + (r_prof_q[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768));
    assign diff        = DIFF_W'(r_rnd) - DIFF_W'(r_mb);
    assign diff_abs    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign meas_abs    = r_mb[DATA_W-1] ? DATA_W'(-r_mb) : DATA_W'(r_mb);

    always_ff @(posedge i_clk) begin
        r_rnd <= RND_W'(prof_biased >>> 16);
        r_mb  <= r_meas_q;
        r_ad  <= diff_abs[DIFF_W-2:0];
        r_am  <= meas_abs;
        r_sqd <= r_ad * r_ad;
        r_sqm <= r_am * r_am;
        if (i_cmd.fin_clr) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_f4_v) begin
            r_num <= r_num + SUM_W'(r_sqd);
            r_den <= r_den + SUM_W'(r_sqm);
        end
    end

    // ratio, divide and root
    assign den_zero    = r_den == '0;
    assign num_big     = {8'b0, r_num} >= {r_den, 8'b0};
    assign gene_div_go = i_cmd.w_start && i_mode && (r_gsum != '0);
    assign q_div_go    = i_cmd.qdiv_start && !den_zero && !num_big;
    assign div_rem     = gene_div_go ? SUM_W'(r_gene_q >> 1) : {8'b0, r_num[SUM_W-1:8]};
    assign div_low     = gene_div_go ? {r_gene_q[0], 39'b0} : {r_num[7:0], 32'b0};
    assign div_den     = gene_div_go ? SUM_W'(r_gsum) : r_den;
    assign div_steps   = gene_div_go ? GENE_DIV_STEPS : Q_DIV_STEPS;

    always_ff @(posedge i_clk) begin
        if (gene_div_go) begin
            r_div_gene <= 1'b1;
        end else if (i_cmd.qdiv_start) begin
            r_div_gene <= 1'b0;
        end
        if (i_cmd.qdiv_start) begin
            r_sat <= den_zero || num_big;
        end
        if (i_cmd.res_load) begin
            o_q_factor         <= r_sat ? Q_MAX : root;
            o_zero_denominator <= den_zero;
            o_zero_gene_sum    <= i_mode && (r_gsum == '0);
        end
    end

    ewqf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gene_div_go || q_div_go),
        .i_rem   (div_rem),
        .i_den   (div_den),
        .i_low   (div_low),
        .i_steps (div_steps),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ewqf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start && !r_sat),
        .i_x     (div_quo),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    assign o_stat.pipe_busy = r_gs_v || r_m1_v || r_m2_v || r_f1_v || r_f2_v || r_f3_v || r_f4_v;
    assign o_stat.div_busy  = div_busy;
    assign o_stat.sqrt_busy = sqrt_busy;
endmodule

// File: rtl/ewqf_ctrl.sv
// Controller: evaluation sequencer, row and point counters, result handshake.
module ewqf_ctrl #(
    parameter  int MAX_CONFS  = 64,
    parameter  int MAX_POINTS = 64,
    localparam int CW         = $clog2(MAX_CONFS),
    localparam int PW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CNW        = $clog2(MAX_CONFS + 1),
    localparam int PNW        = $clog2(MAX_POINTS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_mode,
    input  logic [CNW-1:0]  i_nc,
    input  logic [PNW-1:0]  i_np,
    input  ewqf_pkg::t_stat i_stat,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output ewqf_pkg::t_cmd  o_cmd,
    output logic [CW-1:0]   o_conf,
    output logic [PW-1:0]   o_point
);
    import ewqf_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_ci;
    logic [PW-1:0] r_pi;
    logic          r_out_valid;
    logic          ci_end, pi_end, slot_free;

    assign ci_end    = CNW'(r_ci) == (i_nc - CNW'(1));
    assign pi_end    = PNW'(r_pi) == (i_np - PNW'(1));
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = i_mode ? S_GSUM : S_WREAD;
            S_GSUM:   if (ci_end) n_state = S_GDRAIN;
            S_GDRAIN: if (!i_stat.pipe_busy) n_state = S_WREAD;
            S_WREAD:  n_state = S_WCALC;
            S_WCALC:  n_state = S_WWAIT;
            S_WWAIT:  if (!i_stat.div_busy) n_state = S_MAC;
            S_MAC:    if (pi_end) n_state = S_MDRAIN;
            S_MDRAIN: if (!i_stat.pipe_busy) n_state = ci_end ? S_FIN : S_WREAD;
            S_FIN:    if (pi_end) n_state = S_FDRAIN;
            S_FDRAIN: if (!i_stat.pipe_busy) n_state = S_QDIV;
            S_QDIV:   n_state = S_QWAIT;
            S_QWAIT:  if (!i_stat.div_busy) n_state = S_SQRT;
            S_SQRT:   n_state = S_SWAIT;
            S_SWAIT:  if (!i_stat.sqrt_busy) n_state = S_DONE;
            S_DONE:   if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.gsum_clr = i_start;
                o_cmd.used_clr = i_start;
                o_cmd.fin_clr  = i_start;
            end
            S_GSUM:  o_cmd.gsum_rd = 1'b1;
            S_WREAD: o_cmd.w_rd = 1'b1;
            S_WCALC: begin
                o_cmd.w_start = 1'b1;
                o_cmd.w_last  = ci_end;
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.mac_first = r_ci == '0;
            end
            S_FIN:   o_cmd.fin_issue = 1'b1;
            S_QDIV:  o_cmd.qdiv_start = 1'b1;
            S_SQRT:  o_cmd.sqrt_start = 1'b1;
            S_DONE:  o_cmd.res_load = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ci        <= '0;
            r_pi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_ci <= '0;
                r_pi <= '0;
            end else if (r_state == S_GSUM) begin
                r_ci <= ci_end ? '0 : r_ci + CW'(1);
            end else if (r_state == S_MAC || r_state == S_FIN) begin
                r_pi <= pi_end ? '0 : r_pi + PW'(1);
            end else if (r_state == S_MDRAIN && !i_stat.pipe_busy && !ci_end) begin
                r_ci <= r_ci + CW'(1);
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_conf      = r_ci;
    assign o_point     = r_pi;
endmodule

// File: rtl/ensemble_weighted_q_factor_unit.sv
// Top level of the ensemble weighted Q factor unit.
//
// Load the table with func 0 transactions (conformation, point, value) and the
// measured vector with func 1. Send one gene per conformation with func 2; the
// gene with last set starts an evaluation. Only that transaction produces a
// result on o_res.
// An evaluation runs over the table row by row, one point per cycle per row.
// After the multiply-accumulate over the table and the error sums, the ratio
// divider and then the root unit run.
// i_in.ready is low while an evaluation runs. The result sits in an output
// register; a stalled receiver holds it, and the block keeps taking loads.
// A new result waits in the sequencer until the previous one is taken.
// Reset is synchronous: counts go to 64, mode to 0, the channels go idle.
// Stores hold no reset value.
module ensemble_weighted_q_factor_unit #(
    parameter int MAX_CONFS  = 64,
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ewqf_in_if.sink                             i_in,
    ewqf_out_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [ewqf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ewqf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ewqf_pkg::*;

    localparam int CW  = $clog2(MAX_CONFS);
    localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNW = $clog2(MAX_CONFS + 1);
    localparam int PNW = $clog2(MAX_POINTS + 1);

    logic                  r_mode;
    logic [CFG_DATA_W-1:0] r_conf_cnt;
    logic [CFG_DATA_W-1:0] r_point_cnt;
    logic [CNW-1:0]        nc;
    logic [PNW-1:0]        np;
    logic                  in_ready, in_acc, eval_start;
    t_cmd                  cmd;
    t_stat                 stat;
    logic [CW-1:0]         conf;
    logic [PW-1:0]         point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_conf_cnt  <= CFG_DATA_W'(64);
            r_point_cnt <= CFG_DATA_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WEIGHT_MODE: r_mode      <= i_cfg_data[0];
                CFG_CONF_COUNT:  r_conf_cnt  <= i_cfg_data;
                CFG_POINT_COUNT: r_point_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign nc = (r_conf_cnt == '0) ? CNW'(1) :
                (32'(r_conf_cnt) > MAX_CONFS) ? CNW'(MAX_CONFS) : CNW'(r_conf_cnt);
    assign np = (r_point_cnt == '0) ? PNW'(1) :
                (32'(r_point_cnt) > MAX_POINTS) ? PNW'(MAX_POINTS) : PNW'(r_point_cnt);

    assign in_acc     = i_in.valid && in_ready;
    assign eval_start = in_acc && (i_in.func == FUNC_GENE) && i_in.last;
    assign i_in.ready = in_ready;

    ewqf_ctrl #(
        .MAX_CONFS  (MAX_CONFS),
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (eval_start),
        .i_mode      (r_mode),
        .i_nc        (nc),
        .i_np        (np),
        .i_stat      (stat),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd),
        .o_conf      (conf),
        .o_point     (point)
    );

    ewqf_dp #(
        .MAX_CONFS  (MAX_CONFS),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_acc              (in_acc),
        .i_func             (i_in.func),
        .i_conf_index       (i_in.conf_index),
        .i_point_index      (i_in.point_index),
        .i_data_value       (i_in.data_value),
        .i_gene_value       (i_in.gene_value),
        .i_mode             (r_mode),
        .i_cmd              (cmd),
        .i_conf             (conf),
        .i_point            (point),
        .o_stat             (stat),
        .o_q_factor         (o_res.q_factor),
        .o_zero_denominator (o_res.zero_denominator),
        .o_zero_gene_sum    (o_res.zero_gene_sum)
    );
endmodule

// File: rtl/ewqf_checker.sv
// Port checker for the ensemble weighted Q factor unit and its bind.
`include "ensemble_weighted_q_factor_unit_defines.svh"

module ewqf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic [1:0]                i_func,
    input logic                      i_last,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [ewqf_pkg::Q_W-1:0]  i_q,
    input logic                      i_zd
);
    import ewqf_pkg::*;

    `EWQF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `EWQF_ASSERT_NEXT(a_q_stable, i_out_valid && !i_out_ready, $stable(i_q))
    `EWQF_ASSERT_NEXT(a_busy_after_last, i_in_valid && i_in_ready && (i_func == FUNC_GENE) && i_last, !i_in_ready)
    `EWQF_ASSERT_IMPL(a_zero_den_sat, i_out_valid && i_zd, i_q == Q_MAX)
endmodule

bind ensemble_weighted_q_factor_unit ewqf_checker u_ewqf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_func      (i_in.func),
    .i_last      (i_in.last),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_q         (o_res.q_factor),
    .i_zd        (o_res.zero_denominator)
);
